[design/blp_pkg.sv]
// Shared constants, request codes and cell command types for the bounded positional list.
package blp_pkg;

	// Sizes of the list and of its fields.
	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = 8;
	localparam int KIND_W      = 4;
	localparam int OUT_VALUE_W = 32;
	localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;

	// Request kinds carried on the input tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT     = 4'd0,
		KIND_REMOVE     = 4'd1,
		KIND_SEARCH     = 4'd2,
		KIND_SELECT     = 4'd3,
		KIND_REPLACE    = 4'd4,
		KIND_PUSH_FRONT = 4'd5,
		KIND_PUSH_BACK  = 4'd6,
		KIND_POP_FRONT  = 4'd7,
		KIND_POP_BACK   = 4'd8
	} kind_t;

	// Action broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		idx_t     pos;
		idx_t     count;
		value_t   value;
	} cell_cmd_t;

	// One result beat before packing.
	typedef struct packed {
		logic                   is_full;
		logic                   is_empty;
		idx_t                   entry_count;
		logic [OUT_VALUE_W-1:0] read_value;
		idx_t                   found_index;
		logic                   ok;
	} result_t;

endpackage

[design/bounded_positional_list.sv]
// Top level of the bounded positional list: request register, cell chain and result register.
// The list keeps up to CAPACITY values in a row of cells, entry 0 in the first cell. A request
// beat carries the kind on s_tuser and the position and value on s_tdata; each request gives
// exactly one result beat. A request waits in the request register until the result register is
// free and then executes: every cell shifts, loads or holds at once and the result is registered.
// The block takes no new request until the held one has executed. Searches resolve through the
// hit chain that runs along the cells in the execute cycle. A waiting result blocks execution
// and, while a request is held, the acceptance of the next request.
module bounded_positional_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position [7:0], item_value [39:8]
	input  logic [3:0]  s_tuser,   // kind [3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // ok [0], found_index [8:1], read_value [40:9],
	                               // entry_count [48:41], is_empty [49], is_full [50], zero above
);
	import blp_pkg::*;

	logic            req_valid_s1;
	logic [KIND_W-1:0] kind_s1;
	idx_t            pos_s1;
	value_t          value_s1;

	idx_t            count_q;
	logic            m_tvalid_q;
	result_t         result_q;

	logic            exec;
	cell_cmd_t       cmd;
	cell_cmd_t       cmd_exec;
	idx_t            next_count;
	result_t         result_d;
	logic            can_put;
	logic            pos_live;
	idx_t            first_idx;

	value_t          cell_val   [CAPACITY];
	idx_t            found_part [CAPACITY];
	logic [CAPACITY:0] hit_chain;

	assign s_tready = !req_valid_s1;
	assign exec     = req_valid_s1 && (!m_tvalid_q || m_tready);

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			req_valid_s1 <= 1'b1;
		end else if (exec) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			pos_s1   <= s_tdata[7:0];
			value_s1 <= s_tdata[8 +: VALUE_WIDTH];
		end
	end

	// The cell chain.
	assign hit_chain[0] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		value_t left_v;
		value_t right_v;

		if (g == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end

		blp_cell u_cell (
			.clk         (clk),
			.cell_idx    (IDX_W'(g)),
			.cmd         (cmd_exec),
			.left_value  (left_v),
			.right_value (right_v),
			.hit_in      (hit_chain[g]),
			.value       (cell_val[g]),
			.hit_out     (hit_chain[g+1]),
			.found_part  (found_part[g])
		);
	end

	// At most one cell reports its index, so the parts merge by OR.
	always_comb begin
		first_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			first_idx = first_idx | found_part[i];
		end
	end

	assign can_put  = (count_q < IDX_W'(CAPACITY));
	assign pos_live = (pos_s1 < count_q);

	// Decode the request into a cell action and a result.
	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.pos   = pos_s1;
		cmd.count = count_q;
		cmd.value = value_s1;
		next_count = count_q;
		result_d   = '0;

		unique case (kind_s1)
			KIND_INSERT: begin
				if (can_put && (pos_s1 <= count_q)) begin
					cmd.op      = CELL_INSERT;
					next_count  = count_q + IDX_W'(1);
					result_d.ok = 1'b1;
				end
			end
			KIND_PUSH_FRONT: begin
				if (can_put) begin
					cmd.op      = CELL_INSERT;
					cmd.pos     = '0;
					next_count  = count_q + IDX_W'(1);
					result_d.ok = 1'b1;
				end
			end
			KIND_PUSH_BACK: begin
				if (can_put) begin
					cmd.op      = CELL_INSERT;
					cmd.pos     = count_q;
					next_count  = count_q + IDX_W'(1);
					result_d.ok = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (pos_live) begin
					cmd.op      = CELL_REMOVE;
					next_count  = count_q - IDX_W'(1);
					result_d.ok = 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (count_q != '0) begin
					cmd.op      = CELL_REMOVE;
					cmd.pos     = '0;
					next_count  = count_q - IDX_W'(1);
					result_d.ok = 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (count_q != '0) begin
					cmd.op      = CELL_REMOVE;
					cmd.pos     = count_q - IDX_W'(1);
					next_count  = count_q - IDX_W'(1);
					result_d.ok = 1'b1;
				end
			end
			KIND_SEARCH: begin
				result_d.ok          = hit_chain[CAPACITY];
				result_d.found_index = hit_chain[CAPACITY] ? first_idx : count_q;
			end
			KIND_SELECT: begin
				if (pos_live) begin
					result_d.ok         = 1'b1;
					result_d.read_value = OUT_VALUE_W'(cell_val[pos_s1[SLOT_W-1:0]]);
				end else begin
					result_d.read_value = OUT_VALUE_W'(count_q);
				end
			end
			KIND_REPLACE: begin
				if (pos_live) begin
					cmd.op      = CELL_WRITE;
					result_d.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result_d.entry_count = next_count;
		result_d.is_empty    = (next_count == '0);
		result_d.is_full     = (next_count == IDX_W'(CAPACITY));
	end

	// Cells act only in the execute cycle.
	always_comb begin
		cmd_exec = cmd;
		if (!exec) begin
			cmd_exec.op = CELL_HOLD;
		end
	end

	// Count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else if (exec) begin
			count_q    <= next_count;
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, result_q};

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IDX_W'(CAPACITY))
		else $error("entry count above capacity");

	// A stalled result keeps the list from changing.
	a_stall_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(count_q))
		else $error("list changed while a result was stalled");

	// The count moves by at most one per request.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + IDX_W'(1)
			|| count_q == $past(count_q) - IDX_W'(1)))
		else $error("entry count jumped");

endmodule

[design/blp_cell.sv]
// One list slot: holds a value, shifts with its neighbors and reports search hits.
module blp_cell (
	input  logic               clk,
	input  blp_pkg::idx_t      cell_idx,
	input  blp_pkg::cell_cmd_t cmd,
	input  blp_pkg::value_t    left_value,
	input  blp_pkg::value_t    right_value,
	input  logic               hit_in,
	output blp_pkg::value_t    value,
	output logic               hit_out,
	output blp_pkg::idx_t      found_part
);
	import blp_pkg::*;

	value_t         value_q;
	logic           occupied;
	logic           match;
	logic [IDX_W:0] next_idx;

	// A slot is live when it lies below the count.
	assign occupied = (cell_idx < cmd.count);
	assign next_idx = {1'b0, cell_idx} + {{IDX_W{1'b0}}, 1'b1};

	// Search: the first live slot that matches claims the hit chain.
	assign match      = occupied && (value_q == cmd.value);
	assign hit_out    = hit_in | match;
	assign found_part = (match && !hit_in) ? cell_idx : '0;

	assign value = value_q;

	// Insert shifts the tail right, remove shifts it left, write replaces in place.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INSERT: begin
				if (cell_idx == cmd.pos) begin
					value_q <= cmd.value;
				end else if ((cell_idx > cmd.pos) && (cell_idx <= cmd.count)) begin
					value_q <= left_value;
				end
			end
			CELL_REMOVE: begin
				if ((cell_idx >= cmd.pos) && (next_idx < {1'b0, cmd.count})) begin
					value_q <= right_value;
				end
			end
			CELL_WRITE: begin
				if (cell_idx == cmd.pos) begin
					value_q <= cmd.value;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[dv/tb_bounded_positional_list.sv]
// Self-checking testbench for the bounded positional list: stream driver, list predictor and scoreboard.
`timescale 1ns / 1ps

module tb_bounded_positional_list;
	import blp_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_REQUESTS = 1600;
	localparam int QUIET_TAIL  = 200;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int LONG_HOLD_AFTER = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;

	// Kind codes that the block treats as no operation.
	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 4'd9;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 4'd15;

	// List predictor and store of expected result beats.
	class list_scoreboard;
		value_t  entries[CAPACITY];
		int      list_len;
		result_t expected_results[$];
		int      mismatches;
		int      results_checked;
		int      full_seen;
		int      empty_seen;
		int      rejected;

		function new();
			foreach (entries[i]) entries[i] = '0;
			list_len = 0;
			mismatches = 0;
			results_checked = 0;
			full_seen = 0;
			empty_seen = 0;
			rejected = 0;
		endfunction

		// Shift the tail up by one and store the value at pos.
		function bit insert_at(int pos, value_t value);
			if (list_len >= CAPACITY || pos > list_len)
				return 1'b0;
			for (int i = list_len; i > pos; i--)
				entries[i] = entries[i-1];
			entries[pos] = value;
			list_len++;
			return 1'b1;
		endfunction

		// Close the gap left by the entry at pos.
		function bit remove_at(int pos);
			if (list_len == 0 || pos >= list_len)
				return 1'b0;
			for (int i = pos; i + 1 < list_len; i++)
				entries[i] = entries[i+1];
			list_len--;
			return 1'b1;
		endfunction

		// Update the list for one request and return the result beat it gives.
		function result_t apply_request(logic [KIND_W-1:0] code, idx_t pos, value_t value);
			result_t r;
			r = '0;
			case (code)
				KIND_INSERT:     r.ok = insert_at(int'(pos), value);
				KIND_REMOVE:     r.ok = remove_at(int'(pos));
				KIND_SEARCH: begin
					r.found_index = idx_t'(list_len);
					for (int i = 0; i < list_len; i++) begin
						if (entries[i] == value) begin
							r.found_index = idx_t'(i);
							r.ok = 1'b1;
							break;
						end
					end
				end
				KIND_SELECT: begin
					if (int'(pos) < list_len) begin
						r.read_value = entries[pos];
						r.ok = 1'b1;
					end else begin
						r.read_value = list_len;
					end
				end
				KIND_REPLACE: begin
					if (int'(pos) < list_len) begin
						entries[pos] = value;
						r.ok = 1'b1;
					end
				end
				KIND_PUSH_FRONT: r.ok = insert_at(0, value);
				KIND_PUSH_BACK:  r.ok = insert_at(list_len, value);
				KIND_POP_FRONT:  r.ok = remove_at(0);
				KIND_POP_BACK: begin
					if (list_len != 0)
						r.ok = remove_at(list_len - 1);
				end
				default: ;
			endcase
			r.entry_count = idx_t'(list_len);
			r.is_empty    = (list_len == 0);
			r.is_full     = (list_len == CAPACITY);
			return r;
		endfunction

		function void note_request(logic [KIND_W-1:0] code, idx_t pos, value_t value);
			expected_results.push_back(apply_request(code, pos, value));
		endfunction

		// Compare one result beat with the oldest expectation.
		function void check_result(logic [55:0] beat);
			result_t got;
			result_t want;
			got = result_t'(beat[50:0]);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ERROR: result beat %h arrived with nothing expected", beat);
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			full_seen  += want.is_full;
			empty_seen += want.is_empty;
			rejected   += !want.ok;
			if (got !== want || beat[55:51] !== '0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("ERROR: result %0d expected ok=%0d found=%0d value=%h count=%0d empty=%0d full=%0d",
						results_checked, want.ok, want.found_index, want.read_value,
						want.entry_count, want.is_empty, want.is_full);
					$display("       got ok=%0d found=%0d value=%h count=%0d empty=%0d full=%0d pad=%h",
						got.ok, got.found_index, got.read_value, got.entry_count,
						got.is_empty, got.is_full, beat[55:51]);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position [7:0], item_value [39:8]
	logic [3:0]  s_tuser;   // kind [3:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // ok [0], found_index [8:1], read_value [40:9],
	                        // entry_count [48:41], is_empty [49], is_full [50]

	list_scoreboard sb;
	int  requests_accepted = 0;
	int  cycle_count = 0;
	bit  quiet_tail = 1'b0;

	bounded_positional_list DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Result receiver: random stalls, one long hold-off, and none in the tail.
	initial begin : receiver
		bit long_hold_done;
		long_hold_done = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!long_hold_done && requests_accepted >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(2, 0) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(17, 1)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 1)) @(posedge clk);
			end
		end
	end

	// Offer one request beat, with an optional idle burst first, and wait for acceptance.
	task automatic send_request(input logic [KIND_W-1:0] code, input idx_t pos,
	                            input value_t value);
		int gap;
		if (!quiet_tail && $urandom_range(3, 0) == 0) begin
			gap = $urandom_range(17, 1);
			s_tvalid <= 1'b0;
			s_tdata  <= {32'($urandom()), 8'($urandom())};
			s_tuser  <= 4'($urandom());
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= {value, pos};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_request(code, pos, value);
		requests_accepted++;
	endtask

	// Random traffic that swings the list between empty and full.
	task automatic run_random_requests(input int total);
		bit              growing;
		int              pick;
		logic [KIND_W-1:0] code;
		idx_t            pos;
		value_t          value;
		growing = 1'b1;
		for (int n = 0; n < total; n++) begin
			quiet_tail = (n >= total - QUIET_TAIL);
			if (sb.list_len == CAPACITY && $urandom_range(3, 0) == 0)
				growing = 1'b0;
			else if (sb.list_len == 0 && $urandom_range(3, 0) == 0)
				growing = 1'b1;

			pick = $urandom_range(99, 0);
			if (pick < 3) begin
				code = 4'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
			end else if (pick < 55) begin
				case ($urandom_range(2, 0))
					0:       code = growing ? KIND_INSERT : KIND_REMOVE;
					1:       code = growing ? KIND_PUSH_FRONT : KIND_POP_FRONT;
					default: code = growing ? KIND_PUSH_BACK : KIND_POP_BACK;
				endcase
			end else begin
				code = 4'($urandom_range(KIND_POP_BACK, KIND_INSERT));
			end

			pick = $urandom_range(99, 0);
			if (pick < 85)
				pos = idx_t'($urandom_range(sb.list_len, 0));
			else if (pick < 90)
				pos = idx_t'(sb.list_len + 1);
			else
				pos = idx_t'($urandom_range(255, 0));

			// Reuse stored values often so that searches hit and duplicates occur.
			pick = $urandom_range(99, 0);
			if (pick < 40 && sb.list_len > 0)
				value = sb.entries[$urandom_range(sb.list_len - 1, 0)];
			else if (pick < 60)
				value = value_t'($urandom_range(3, 0));
			else
				value = $urandom();

			send_request(code, pos, value);
		end
	endtask

	// Reset, directed corner cases, random traffic, drain and verdict.
	initial begin : main
		sb = new();
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every request on the empty list is rejected or reports the empty count.
		send_request(KIND_POP_FRONT,  8'd0,   32'h0);
		send_request(KIND_POP_BACK,   8'd0,   32'h0);
		send_request(KIND_REMOVE,     8'd0,   32'h0);
		send_request(KIND_SELECT,     8'd0,   32'h0);
		send_request(KIND_SEARCH,     8'd0,   32'h0);
		send_request(KIND_REPLACE,    8'd0,   32'hFFFF_FFFF);
		send_request(KIND_INSERT,     8'd1,   32'h1234_5678);
		// Build a short list with extreme values.
		send_request(KIND_INSERT,     8'd0,   32'hFFFF_FFFF);
		send_request(KIND_PUSH_FRONT, 8'd255, 32'h0);
		send_request(KIND_PUSH_BACK,  8'd255, 32'hA5A5_5A5A);
		send_request(KIND_INSERT,     8'd3,   32'h8000_0001);
		send_request(KIND_INSERT,     8'd255, 32'h1);
		send_request(KIND_SEARCH,     8'd0,   32'hFFFF_FFFF);
		send_request(KIND_SEARCH,     8'd0,   32'h5555_AAAA);
		send_request(KIND_SELECT,     8'd255, 32'h0);
		send_request(KIND_SELECT,     8'd1,   32'h0);
		send_request(KIND_REPLACE,    8'd2,   32'h0F0F_F0F0);
		send_request(KIND_REPLACE,    8'd4,   32'h3);
		send_request(KIND_REMOVE,     8'd4,   32'h0);
		send_request(KIND_REMOVE,     8'd1,   32'h0);
		send_request(KIND_UNUSED_FIRST, 8'd0, 32'hFFFF_FFFF);
		send_request(KIND_UNUSED_LAST,  8'd255, 32'h0);
		send_request(KIND_POP_BACK,   8'd0,   32'h0);
		send_request(KIND_POP_FRONT,  8'd0,   32'h0);

		run_random_requests(RANDOM_REQUESTS);
		s_tvalid <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests over all kind codes; checked %0d result beats.",
			requests_accepted, sb.results_checked);
		$display("List was full on %0d results and empty on %0d; %0d requests were rejected.",
			sb.full_seen, sb.empty_seen, sb.rejected);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.expected_results.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
